>>> sv/cht_pkg.sv
// shared types and constants for the chained hash table engine
package cht_pkg;

  // default table geometry
  localparam int NUM_BUCKETS_DEF = 64;
  localparam int NUM_ENTRIES_DEF = 256;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;

  // request codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd3;

  // sequencer states
  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_HASH   = 11'b00000000100,
    S_SEL    = 11'b00000001000,
    S_ADD_WR = 11'b00000010000,
    S_HEAD   = 11'b00000100000,
    S_WALK   = 11'b00001000000,
    S_CMP    = 11'b00010000000,
    S_REM1   = 11'b00100000000,
    S_REM2   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

endpackage

>>> sv/cht_ram.sv
// generic single-write, single-read ram with registered read data
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/cht_bucket_div.sv
// key modulo bucket count by byte folding and a reciprocal multiply
module cht_bucket_div #(
  parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
  localparam int BAW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [cht_pkg::KEY_W-1:0] key,
  output logic                     done,
  output logic [BAW-1:0]           bucket
);

  // folded key width, reciprocal shift and widths
  localparam int NW = $clog2(NUM_BUCKETS + 1);
  localparam int YW = NW + 10;
  localparam int SH = YW + $clog2(NUM_BUCKETS);
  localparam int MW = YW + 2;
  localparam int PW = YW + MW;
  localparam logic [NW-1:0] NB = NW'(NUM_BUCKETS);
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  // weight of each key byte modulo the bucket count
  localparam logic [NW-1:0] W0 = NW'(64'd1 % 64'(NUM_BUCKETS));
  localparam logic [NW-1:0] W1 = NW'((64'd1 << 8) % 64'(NUM_BUCKETS));
  localparam logic [NW-1:0] W2 = NW'((64'd1 << 16) % 64'(NUM_BUCKETS));
  localparam logic [NW-1:0] W3 = NW'((64'd1 << 24) % 64'(NUM_BUCKETS));

  logic [YW-1:0]  sum_r, sum_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic [BAW-1:0] rem_r, rem_nxt;
  logic           v1_r, v2_r, done_r;

  // fold the bytes, take the quotient, subtract it back out
  always_comb begin
    logic [NW+7:0]    p0, p1, p2, p3;
    logic [YW-1:0]    q;
    logic [YW+NW-1:0] qn;
    logic [YW-1:0]    r;
    p0 = key[7:0] * W0;
    p1 = key[15:8] * W1;
    p2 = key[23:16] * W2;
    p3 = key[31:24] * W3;
    q  = YW'(prod_r >> SH);
    qn = q * NB;
    r  = sum_r - qn[YW-1:0];
    sum_nxt  = start ? (YW'(p0) + YW'(p1) + YW'(p2) + YW'(p3)) : sum_r;
    prod_nxt = v1_r ? sum_r * RECIP : prod_r;
    rem_nxt  = v2_r ? r[BAW-1:0] : rem_r;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule

>>> sv/chained_hash_table_engine.sv
// chained hash table engine: bucket heads, entry data and links in rams
// sequence: the key is folded to a bucket and the head is read; an add then links the new entry
//   at the chain head, get and remove walk the chain comparing keys, and remove then unlinks the
//   entry and frees it; rejected adds and the unused op skip ahead; the result is then registered
// one item at a time; the next is taken the cycle after a result is loaded
// reset: the bucket heads are cleared in turn; free pool tracked by a fill count
module chained_hash_table_engine #(
  parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
  parameter int NUM_ENTRIES = cht_pkg::NUM_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cht_pkg::OP_W-1:0]     in_op,
  input  logic [cht_pkg::KEY_W-1:0]    in_key,
  input  logic [cht_pkg::HANDLE_W-1:0] in_handle,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cht_pkg::STATUS_W-1:0] out_status,
  output logic [cht_pkg::HANDLE_W-1:0] out_found_handle
);

  localparam int IW  = $clog2(NUM_ENTRIES + 1);
  localparam int EAW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int BAW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int DW  = cht_pkg::KEY_W + cht_pkg::HANDLE_W;
  localparam logic [IW-1:0] NULL_IDX = IW'(NUM_ENTRIES);

  cht_pkg::state_t state_r, state_nxt;

  logic [cht_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [cht_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [cht_pkg::HANDLE_W-1:0] hnd_r, hnd_nxt;
  logic [IW-1:0]                cur_r, cur_nxt;
  logic [IW-1:0]                prev_r, prev_nxt;
  logic [IW-1:0]                link_r, link_nxt;
  logic [IW-1:0]                steps_r, steps_nxt;
  logic [IW-1:0]                free_head_r, free_head_nxt;
  logic [IW-1:0]                fill_r, fill_nxt;
  logic [BAW-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic [cht_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [cht_pkg::HANDLE_W-1:0] res_found_r, res_found_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [cht_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [cht_pkg::HANDLE_W-1:0] out_found_r, out_found_nxt;

  logic           div_start, div_done;
  logic [BAW-1:0] bucket;

  logic           bh_we;
  logic [BAW-1:0] bh_waddr;
  logic [IW-1:0]  bh_wdata, bh_rdata;
  logic           lk_we;
  logic [EAW-1:0] lk_waddr, lk_raddr;
  logic [IW-1:0]  lk_wdata, lk_rdata;
  logic           dt_we;
  logic [DW-1:0]  dt_rdata;
  logic           in_acc;

  // bucket index unit
  cht_bucket_div #(.NUM_BUCKETS(NUM_BUCKETS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .key    (key_nxt),
    .done   (div_done),
    .bucket (bucket)
  );

  // bucket head memory
  cht_ram #(.WIDTH(IW), .DEPTH(NUM_BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (bh_we),
    .waddr (bh_waddr),
    .wdata (bh_wdata),
    .raddr (bucket),
    .rdata (bh_rdata)
  );

  // entry link memory
  cht_ram #(.WIDTH(IW), .DEPTH(NUM_ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  // entry key and handle memory
  cht_ram #(.WIDTH(DW), .DEPTH(NUM_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (dt_we),
    .waddr (free_head_r[EAW-1:0]),
    .wdata ({key_r, hnd_r}),
    .raddr (cur_r[EAW-1:0]),
    .rdata (dt_rdata)
  );

  assign in_stall  = (state_r != cht_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign div_start = in_acc;
  assign lk_raddr  = (op_r == cht_pkg::OP_ADD) ? free_head_r[EAW-1:0] : cur_r[EAW-1:0];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hnd_nxt        = hnd_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    link_nxt       = link_r;
    steps_nxt      = steps_r;
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    clr_cnt_nxt    = clr_cnt_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    bh_we          = 1'b0;
    bh_waddr       = bucket;
    bh_wdata       = NULL_IDX;
    lk_we          = 1'b0;
    lk_waddr       = cur_r[EAW-1:0];
    lk_wdata       = free_head_r;
    dt_we          = 1'b0;
    case (state_r)
      cht_pkg::S_CLEAR: begin
        bh_we    = 1'b1;
        bh_waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BAW'(NUM_BUCKETS - 1)) begin
          state_nxt = cht_pkg::S_IDLE;
        end
      end
      cht_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_op;
          key_nxt   = in_key;
          hnd_nxt   = in_handle;
          state_nxt = cht_pkg::S_HASH;
        end
      end
      cht_pkg::S_HASH: begin
        if (div_done) begin
          state_nxt = cht_pkg::S_SEL;
        end
      end
      cht_pkg::S_SEL: begin
        // reads of head and free link are issued here
        res_status_nxt = cht_pkg::ST_MISS;
        res_found_nxt  = '0;
        if (op_r == cht_pkg::OP_ADD) begin
          if (hnd_r == '0) begin
            res_status_nxt = cht_pkg::ST_ZERO;
            state_nxt      = cht_pkg::S_DONE;
          end else if (free_head_r == NULL_IDX) begin
            res_status_nxt = cht_pkg::ST_FULL;
            state_nxt      = cht_pkg::S_DONE;
          end else begin
            state_nxt = cht_pkg::S_ADD_WR;
          end
        end else if (op_r == cht_pkg::OP_GET || op_r == cht_pkg::OP_REMOVE) begin
          state_nxt = cht_pkg::S_HEAD;
        end else begin
          state_nxt = cht_pkg::S_DONE;
        end
      end
      cht_pkg::S_ADD_WR: begin
        // link new entry at chain head, pop the free pool
        dt_we    = 1'b1;
        lk_we    = 1'b1;
        lk_waddr = free_head_r[EAW-1:0];
        lk_wdata = bh_rdata;
        bh_we    = 1'b1;
        bh_wdata = free_head_r;
        if (free_head_r == fill_r) begin
          free_head_nxt = fill_r + 1'b1;
          fill_nxt      = fill_r + 1'b1;
        end else begin
          free_head_nxt = lk_rdata;
        end
        res_status_nxt = cht_pkg::ST_OK;
        state_nxt      = cht_pkg::S_DONE;
      end
      cht_pkg::S_HEAD: begin
        cur_nxt   = bh_rdata;
        prev_nxt  = NULL_IDX;
        steps_nxt = '0;
        state_nxt = cht_pkg::S_WALK;
      end
      cht_pkg::S_WALK: begin
        if (cur_r == NULL_IDX || steps_r == NULL_IDX) begin
          state_nxt = cht_pkg::S_DONE;
        end else begin
          state_nxt = cht_pkg::S_CMP;
        end
      end
      cht_pkg::S_CMP: begin
        // compare key of the current entry
        link_nxt = lk_rdata;
        if (dt_rdata[DW-1 -: cht_pkg::KEY_W] == key_r) begin
          res_status_nxt = cht_pkg::ST_OK;
          res_found_nxt  = dt_rdata[cht_pkg::HANDLE_W-1:0];
          state_nxt = (op_r == cht_pkg::OP_REMOVE) ? cht_pkg::S_REM1 : cht_pkg::S_DONE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lk_rdata;
          steps_nxt = steps_r + 1'b1;
          state_nxt = cht_pkg::S_WALK;
        end
      end
      cht_pkg::S_REM1: begin
        // bypass the matched entry
        if (prev_r == NULL_IDX) begin
          bh_we    = 1'b1;
          bh_wdata = link_r;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = prev_r[EAW-1:0];
          lk_wdata = link_r;
        end
        state_nxt = cht_pkg::S_REM2;
      end
      cht_pkg::S_REM2: begin
        // push the entry onto the free pool
        lk_we         = 1'b1;
        free_head_nxt = cur_r;
        state_nxt     = cht_pkg::S_DONE;
      end
      cht_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          state_nxt      = cht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cht_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cht_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hnd_r        <= hnd_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    link_r       <= link_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_handle = out_found_r;

endmodule
